// File: design/mfc_pkg.sv
// Shared types, constants and register indexes for the meter frame checker.
package mfc_pkg;

  localparam int LengthBits = 16;
  localparam logic [15:0] LenMask = 16'((32'h1 << LengthBits) - 1);
  localparam logic [15:0] MinLegalLen = 16'd5;

  localparam logic [7:0]  StartMarkerRst = 8'h68;
  localparam logic [7:0]  EndMarkerRst   = 8'h16;
  localparam logic [7:0]  LastMaskRst    = 8'h40;
  localparam logic [7:0]  FlagOffsetRst  = 8'd7;
  localparam logic [15:0] MinLenRst      = 16'd9;

  typedef enum logic [2:0] {
    CfgStartMarker = 3'd0,
    CfgEndMarker   = 3'd1,
    CfgLastMask    = 3'd2,
    CfgFlagOffset  = 3'd3,
    CfgMinLength   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StInFrame = 3'd0,
    StDropped = 3'd1,
    StLast    = 3'd2,
    StMiddle  = 3'd3,
    StBadEnd  = 3'd4,
    StBadSum  = 3'd5,
    StShort   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    KindInFrame = 2'd0,
    KindDrop    = 2'd1,
    KindShort   = 2'd2,
    KindDone    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [7:0]  last_mask;
    logic [7:0]  flag_offset;
    logic [15:0] min_length;
  } cfg_t;

  // One classified beat on its way to the output stage.
  typedef struct packed {
    logic [7:0]  byte_val;
    logic [15:0] position;
    logic [15:0] length;
    kind_e       kind;
    logic        end_ok;
    logic        sum_ok;
    logic        len_ok;
    logic        last;
  } beat_t;

endpackage

// File: design/mfc_front.sv
// Frame tracker: follows position, length, sum and flag, classifies each beat.
module mfc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mfc_pkg::cfg_t  cfg_i,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  output mfc_pkg::beat_t beat_o
);
  import mfc_pkg::*;

  logic        in_frame_q, in_frame_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  flag_q, flag_d;

  logic [15:0] end_pos;
  logic [15:0] new_len;
  logic [15:0] flag_pos;
  logic [7:0]  sum_add;

  assign end_pos  = len_q - 16'd1;
  assign new_len  = (len_q | {8'h00, data_byte_i}) & LenMask;
  assign flag_pos = {8'h00, cfg_i.flag_offset};
  assign sum_add  = sum_q + data_byte_i;

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    len_d      = len_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    flag_d     = flag_q;

    beat_o          = '0;
    beat_o.byte_val = data_byte_i;
    beat_o.kind     = KindInFrame;
    beat_o.end_ok   = (data_byte_i == cfg_i.end_marker);
    beat_o.sum_ok   = (sum_q == chk_q);
    beat_o.len_ok   = !(len_q < cfg_i.min_length);
    beat_o.last     = ((flag_q & cfg_i.last_mask) != 8'h00);

    if (!in_frame_q) begin
      if (data_byte_i == cfg_i.start_marker) begin
        in_frame_d = 1'b1;
        pos_d      = 16'd1;
        sum_d      = data_byte_i;
        len_d      = '0;
        chk_d      = '0;
        flag_d     = '0;
      end else begin
        beat_o.kind = KindDrop;
      end
    end else begin
      beat_o.position = pos_q;
      if (pos_q == 16'd1) begin
        len_d = {data_byte_i, 8'h00} & LenMask;
        sum_d = sum_add;
        pos_d = 16'd2;
        if (flag_pos == 16'd1) flag_d = data_byte_i;
      end else if (pos_q == 16'd2) begin
        sum_d         = sum_add;
        beat_o.length = new_len;
        if (new_len < MinLegalLen) begin
          // no room for checksum and end marker
          beat_o.kind = KindShort;
          in_frame_d  = 1'b0;
          pos_d       = '0;
          len_d       = '0;
          sum_d       = '0;
          chk_d       = '0;
          flag_d      = '0;
        end else begin
          len_d = new_len;
          pos_d = 16'd3;
          if (flag_pos == 16'd2) flag_d = data_byte_i;
        end
      end else begin
        beat_o.length = len_q;
        if (pos_q < end_pos) begin
          if (pos_q == flag_pos) flag_d = data_byte_i;
          if (pos_q == end_pos - 16'd1) begin
            chk_d = data_byte_i;
          end else begin
            sum_d = sum_add;
          end
          pos_d = pos_q + 16'd1;
        end else begin
          beat_o.kind = KindDone;
          in_frame_d  = 1'b0;
          pos_d       = '0;
          len_d       = '0;
          sum_d       = '0;
          chk_d       = '0;
          flag_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      chk_q      <= '0;
      flag_q     <= '0;
    end else if (accept_i) begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      chk_q      <= chk_d;
      flag_q     <= flag_d;
    end
  end

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (pos_q != 16'd0))
    else $error("in frame with position zero");

  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_frame_q && pos_q >= 16'd3) |-> (len_q >= MinLegalLen))
    else $error("frame body reached with degenerate length");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (beat_o.kind == KindDone || beat_o.kind == KindShort)) |=> !in_frame_q)
    else $error("frame end did not return to hunting");

endmodule

// File: design/mfc_queue.sv
// Two-entry beat queue between the frame tracker and the output stage.
module mfc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mfc_pkg::beat_t push_beat_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output mfc_pkg::beat_t pop_beat_o
);
  import mfc_pkg::*;

  beat_t       entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_beat_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_beat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// File: design/mfc_back.sv
// Output stage: resolves the outcome of each beat into a status and holds the result.
module mfc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  mfc_pkg::beat_t q_beat_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     byte_out_o,
  output logic [15:0]    byte_position_o,
  output logic [15:0]    frame_length_o,
  output logic [2:0]     status_o
);
  import mfc_pkg::*;

  logic        valid_q, valid_d;
  logic [7:0]  byte_q;
  logic [15:0] pos_q;
  logic [15:0] len_q;
  status_e     status_q, status_d;

  assign q_pop_o = q_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    case (q_beat_i.kind)
      KindInFrame: status_d = StInFrame;
      KindDrop:    status_d = StDropped;
      KindShort:   status_d = StShort;
      KindDone: begin
        // end marker first, then checksum, then length
        if (!q_beat_i.end_ok)      status_d = StBadEnd;
        else if (!q_beat_i.sum_ok) status_d = StBadSum;
        else if (!q_beat_i.len_ok) status_d = StShort;
        else if (q_beat_i.last)    status_d = StLast;
        else                       status_d = StMiddle;
      end
      default:     status_d = StInFrame;
    endcase
  end

  always_comb begin
    if (q_pop_o) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
    else valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q   <= q_beat_i.byte_val;
      pos_q    <= q_beat_i.position;
      len_q    <= q_beat_i.length;
      status_q <= status_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign byte_out_o      = byte_q;
  assign byte_position_o = pos_q;
  assign frame_length_o  = len_q;
  assign status_o        = status_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !q_pop_o)
    else $error("output overwritten while stalled");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> valid_q)
    else $error("loaded beat not presented");

  a_drop_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_beat_i.kind == KindDrop) |-> (q_beat_i.position == 16'd0))
    else $error("dropped beat carries a position");

endmodule

// File: design/meter_frame_checker_core.sv
// Top level of the meter frame checker: config registers, tracker, queue, output stage.
//
//  channel  dir  handshake                      payload
//  in       in   in_valid_i / in_stall_o        data_byte_i
//  out      out  out_valid_o / out_stall_i      byte_out_o, byte_position_o,
//                                               frame_length_o, status_o
//  cfg      in   cfg_we_i                       cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while out_stall_i is low; each taken beat
// goes to a queue entry with the tracker state update, then to the output register.
// The per-beat frame state update (position, length, 8-bit sum) sets the rate.
// Reset clears all frame state and loads the register defaults; no warm-up.
// in_stall_o rises only when the two-entry queue is full; with a beat arriving
// every cycle, any stall of the output is enough to fill it.
module meter_frame_checker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_out_o,
  output logic [15:0] byte_position_o,
  output logic [15:0] frame_length_o,
  output logic [2:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mfc_pkg::*;

  cfg_t  cfg_q;
  beat_t front_beat;
  beat_t q_beat;
  logic  accept;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= StartMarkerRst;
      cfg_q.end_marker   <= EndMarkerRst;
      cfg_q.last_mask    <= LastMaskRst;
      cfg_q.flag_offset  <= FlagOffsetRst;
      cfg_q.min_length   <= MinLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgStartMarker: cfg_q.start_marker <= cfg_data_i[7:0];
        CfgEndMarker:   cfg_q.end_marker   <= cfg_data_i[7:0];
        CfgLastMask:    cfg_q.last_mask    <= cfg_data_i[7:0];
        CfgFlagOffset:  cfg_q.flag_offset  <= cfg_data_i[7:0];
        CfgMinLength:   cfg_q.min_length   <= cfg_data_i;
        default:        cfg_q              <= cfg_q;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  mfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .beat_o      (front_beat)
  );

  mfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_beat_i (front_beat),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_beat_o  (q_beat)
  );

  mfc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_beat_i        (q_beat),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_out_o      (byte_out_o),
    .byte_position_o (byte_position_o),
    .frame_length_o  (frame_length_o),
    .status_o        (status_o)
  );

endmodule
